// ----- sv/tsbo_pkg.sv -----
// ----------------------------------------------------------------------------
// tsbo_pkg
// Shared types and constants for the tiled surface byte offset unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tsbo_pkg;

  localparam int PIPE_BITS    = 3;
  localparam int BANK_BITS    = 4;
  localparam int PW_BITS      = 15;
  localparam int LOG2_BITS    = 4;
  localparam int BNK_LOG2_BITS = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 15;
  localparam int OFFSET_BITS  = 32;
  // Bits of the linear offset that can still reach the 32-bit result.
  localparam int MT_KEEP_BITS = OFFSET_BITS - PIPE_BITS - BANK_BITS;
  // t_index * 256 + element * 4
  localparam int LO_BITS      = 14;
  localparam int SH_BITS      = 5;

  // Macro tile bytes = 2^(w_log2 + h_log2 - 5) when both log2 sizes reach 3.
  localparam logic [LOG2_BITS-1:0] MICRO_TILE_LOG2 = 4'd3;
  localparam logic [SH_BITS-1:0]   MT_SHIFT_BIAS   = 5'd5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PADDED_WIDTH    = 3'd0,
    REG_MT_WIDTH_LOG2   = 3'd1,
    REG_MT_HEIGHT_LOG2  = 3'd2,
    REG_BANK_WIDTH_LOG2 = 3'd3,
    REG_BANK_HEIGHT_LOG2 = 3'd4,
    REG_INTERLEAVE_BITS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [PW_BITS-1:0]       padded_width;
    logic [LOG2_BITS-1:0]     mt_width_log2;
    logic [LOG2_BITS-1:0]     mt_height_log2;
    logic [BNK_LOG2_BITS-1:0] bank_width_log2;
    logic [BNK_LOG2_BITS-1:0] bank_height_log2;
    logic [LOG2_BITS-1:0]     interleave_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    padded_width:     15'd1920,
    mt_width_log2:    4'd7,
    mt_height_log2:   4'd6,
    bank_width_log2:  2'd0,
    bank_height_log2: 2'd0,
    interleave_bits:  4'd8
  };

  // Fields that ride along the pipeline untouched until the final pack.
  typedef struct packed {
    logic [LO_BITS-1:0]   lo;
    logic [PIPE_BITS-1:0] pipe;
    logic [BANK_BITS-1:0] bank;
  } side_t;

endpackage

`default_nettype wire

// ----- sv/tiled_surface_byte_offset_unit.sv -----
// ----------------------------------------------------------------------------
// tiled_surface_byte_offset_unit
// Pixel coordinate to byte offset in a 2D-thin macro-tiled 32-bit surface
// with 8 pipes and 16 banks. A request is taken on every clock where start
// is high (busy is always low) and its offset appears on out_byte_offset,
// marked by a one-cycle out_valid, once it has passed the five register
// stages: decode, row multiply, macro tile index add, tile scale and add,
// and the pipe/bank insertion. One request per clock is sustained.
// Results cannot be held off, so the receiver must take each one in the
// cycle it is shown. Write configuration only while no request is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_surface_byte_offset_unit
  import tsbo_pkg::*;
#(
  parameter int COORD_BITS = 14
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [COORD_BITS-1:0]    in_pixel_x,
  input  wire logic [COORD_BITS-1:0]    in_pixel_y,
  output logic                          out_valid,
  output logic [OFFSET_BITS-1:0]        out_byte_offset,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t                    cfg;
  logic                    s1_valid;
  logic [COORD_BITS-1:0]   s1_x_mt;
  logic [COORD_BITS-1:0]   s1_y_mt;
  logic [PW_BITS-1:0]      s1_per_row;
  side_t                   s1_side;
  logic                    s4_valid;
  logic [MT_KEEP_BITS-1:0] s4_total;
  side_t                   s4_side;

  // Every stage advances each clock, so a request is never refused.
  assign busy = 1'b0;

  tsbo_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsbo_decode #(
    .COORD_BITS (COORD_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (start && !busy),
    .in_x       (in_pixel_x),
    .in_y       (in_pixel_y),
    .s1_valid   (s1_valid),
    .s1_x_mt    (s1_x_mt),
    .s1_y_mt    (s1_y_mt),
    .s1_per_row (s1_per_row),
    .s1_side    (s1_side)
  );

  tsbo_offset #(
    .COORD_BITS (COORD_BITS)
  ) u_offset (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_x_mt    (s1_x_mt),
    .s1_y_mt    (s1_y_mt),
    .s1_per_row (s1_per_row),
    .s1_side    (s1_side),
    .s4_valid   (s4_valid),
    .s4_total   (s4_total),
    .s4_side    (s4_side)
  );

  tsbo_pack u_pack (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .s4_valid        (s4_valid),
    .s4_total        (s4_total),
    .s4_side         (s4_side),
    .out_valid       (out_valid),
    .out_byte_offset (out_byte_offset)
  );

`ifndef SYNTH
  // Each result traces back to a request taken while out of reset.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 5))
    else $error("result without a matching request");

  // A request taken with no reset in between always yields a result.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && !busy, 5) && $past(rst_n, 5) && $past(rst_n, 4) &&
     $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)) |-> out_valid)
    else $error("request lost in pipeline");

  // The stage 4 valid bit is the only source of the output strobe.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(s4_valid)))
    else $error("output strobe out of step with stage 4");
`endif

endmodule

`default_nettype wire

// ----- sv/tsbo_cfg.sv -----
// ----------------------------------------------------------------------------
// tsbo_cfg
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tsbo_cfg
  import tsbo_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                          cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_PADDED_WIDTH:     cfg_nxt.padded_width     = cfg_wdata[PW_BITS-1:0];
        REG_MT_WIDTH_LOG2:    cfg_nxt.mt_width_log2    = cfg_wdata[LOG2_BITS-1:0];
        REG_MT_HEIGHT_LOG2:   cfg_nxt.mt_height_log2   = cfg_wdata[LOG2_BITS-1:0];
        REG_BANK_WIDTH_LOG2:  cfg_nxt.bank_width_log2  = cfg_wdata[BNK_LOG2_BITS-1:0];
        REG_BANK_HEIGHT_LOG2: cfg_nxt.bank_height_log2 = cfg_wdata[BNK_LOG2_BITS-1:0];
        REG_INTERLEAVE_BITS:  cfg_nxt.interleave_bits  = cfg_wdata[LOG2_BITS-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- sv/tsbo_decode.sv -----
// ----------------------------------------------------------------------------
// tsbo_decode
// Stage 1: split the coordinate into macro tile position, micro tile and
// element bits, and form the pipe and bank swizzles.
// ----------------------------------------------------------------------------
`default_nettype none

module tsbo_decode
  import tsbo_pkg::*;
#(
  parameter int COORD_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  cfg_t                       cfg,
  input  wire logic                  in_valid,
  input  wire logic [COORD_BITS-1:0] in_x,
  input  wire logic [COORD_BITS-1:0] in_y,
  output logic                       s1_valid,
  output logic [COORD_BITS-1:0]      s1_x_mt,
  output logic [COORD_BITS-1:0]      s1_y_mt,
  output logic [PW_BITS-1:0]         s1_per_row,
  output side_t                      s1_side
);

  logic [OFFSET_BITS-1:0] xs;
  logic [OFFSET_BITS-1:0] ys;
  logic [2:0]             bw_mask;
  logic [2:0]             bh_mask;
  logic [2:0]             t_row;
  logic [2:0]             t_col;
  logic [5:0]             t_index;
  logic [5:0]             elem;
  side_t                  side_nxt;

  logic                   valid_r;
  logic [COORD_BITS-1:0]  x_mt_r;
  logic [COORD_BITS-1:0]  y_mt_r;
  logic [PW_BITS-1:0]     per_row_r;
  side_t                  side_r;

  // Bank swizzle looks at coordinates scaled by bank size; bits past the
  // coordinate width read as zero.
  assign xs = OFFSET_BITS'(in_x) >> (SH_BITS'(cfg.bank_width_log2) + SH_BITS'(PIPE_BITS));
  assign ys = OFFSET_BITS'(in_y) >> cfg.bank_height_log2;

  assign bw_mask = 3'((4'd1 << cfg.bank_width_log2) - 4'd1);
  assign bh_mask = 3'((4'd1 << cfg.bank_height_log2) - 4'd1);
  assign t_row   = in_y[5:3] & bh_mask;
  assign t_col   = in_x[8:6] & bw_mask;
  assign t_index = (6'(t_row) << cfg.bank_width_log2) + 6'(t_col);
  assign elem    = {in_y[2], in_y[1], in_x[2], in_y[0], in_x[1], in_x[0]};

  always_comb begin
    side_nxt.lo   = {t_index, elem, 2'b00};
    side_nxt.pipe = {in_x[5] ^ in_y[5], in_x[4] ^ in_y[4], in_x[3] ^ in_y[3] ^ in_x[4]};
    side_nxt.bank = {xs[6] ^ ys[3], xs[5] ^ ys[4], xs[4] ^ ys[5] ^ ys[6], xs[3] ^ ys[6]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_mt_r    <= in_x >> cfg.mt_width_log2;
    y_mt_r    <= in_y >> cfg.mt_height_log2;
    per_row_r <= cfg.padded_width >> cfg.mt_width_log2;
    side_r    <= side_nxt;
  end

  assign s1_valid   = valid_r;
  assign s1_x_mt    = x_mt_r;
  assign s1_y_mt    = y_mt_r;
  assign s1_per_row = per_row_r;
  assign s1_side    = side_r;

endmodule

`default_nettype wire

// ----- sv/tsbo_offset.sv -----
// ----------------------------------------------------------------------------
// tsbo_offset
// Stages 2 to 4: macro tile row multiply, macro tile index add, then scale
// by the macro tile size and add the micro tile and element offset.
// ----------------------------------------------------------------------------
`default_nettype none

module tsbo_offset
  import tsbo_pkg::*;
#(
  parameter int COORD_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  cfg_t                       cfg,
  input  wire logic                  s1_valid,
  input  wire logic [COORD_BITS-1:0] s1_x_mt,
  input  wire logic [COORD_BITS-1:0] s1_y_mt,
  input  wire logic [PW_BITS-1:0]    s1_per_row,
  input  side_t                      s1_side,
  output logic                       s4_valid,
  output logic [MT_KEEP_BITS-1:0]    s4_total,
  output side_t                      s4_side
);

  localparam int PROD_BITS = COORD_BITS + PW_BITS;

  logic                    s2_valid_r;
  logic [PROD_BITS-1:0]    s2_prod_r;
  logic [COORD_BITS-1:0]   s2_x_mt_r;
  side_t                   s2_side_r;

  logic                    s3_valid_r;
  logic [MT_KEEP_BITS-1:0] s3_mt_idx_r;
  side_t                   s3_side_r;

  logic                    s4_valid_r;
  logic [MT_KEEP_BITS-1:0] s4_total_r;
  logic [MT_KEEP_BITS-1:0] s4_total_nxt;
  side_t                   s4_side_r;

  logic [SH_BITS-1:0]      sh;
  logic                    sh_ok;
  logic [MT_KEEP_BITS-1:0] mt_part;

  // Macro tile bytes are a power of two; tiles under one micro tile count as zero.
  assign sh    = SH_BITS'(cfg.mt_width_log2) + SH_BITS'(cfg.mt_height_log2) - MT_SHIFT_BIAS;
  assign sh_ok = (cfg.mt_width_log2 >= MICRO_TILE_LOG2) &&
                 (cfg.mt_height_log2 >= MICRO_TILE_LOG2) &&
                 (sh < SH_BITS'(MT_KEEP_BITS));

  always_comb begin
    mt_part      = sh_ok ? (s3_mt_idx_r << sh) : '0;
    s4_total_nxt = mt_part + MT_KEEP_BITS'(s3_side_r.lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_prod_r   <= PROD_BITS'(s1_y_mt) * PROD_BITS'(s1_per_row);
    s2_x_mt_r   <= s1_x_mt;
    s2_side_r   <= s1_side;
    // Only the low bits survive the final truncation.
    s3_mt_idx_r <= s2_prod_r[MT_KEEP_BITS-1:0] + MT_KEEP_BITS'(s2_x_mt_r);
    s3_side_r   <= s2_side_r;
    s4_total_r  <= s4_total_nxt;
    s4_side_r   <= s3_side_r;
  end

  assign s4_valid = s4_valid_r;
  assign s4_total = s4_total_r;
  assign s4_side  = s4_side_r;

endmodule

`default_nettype wire

// ----- sv/tsbo_pack.sv -----
// ----------------------------------------------------------------------------
// tsbo_pack
// Stage 5: insert pipe and bank bits above the pipe interleave bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tsbo_pack
  import tsbo_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  cfg_t                         cfg,
  input  wire logic                    s4_valid,
  input  wire logic [MT_KEEP_BITS-1:0] s4_total,
  input  side_t                        s4_side,
  output logic                         out_valid,
  output logic [OFFSET_BITS-1:0]       out_byte_offset
);

  logic [OFFSET_BITS-1:0] total;
  logic [OFFSET_BITS-1:0] low_mask;
  logic [OFFSET_BITS-1:0] high;
  logic [OFFSET_BITS-1:0] result_nxt;
  logic [SH_BITS-1:0]     ib;

  logic                   valid_r;
  logic [OFFSET_BITS-1:0] result_r;

  assign ib       = SH_BITS'(cfg.interleave_bits);
  assign total    = OFFSET_BITS'(s4_total);
  assign low_mask = (OFFSET_BITS'(1) << ib) - OFFSET_BITS'(1);
  assign high     = total >> ib;

  always_comb begin
    result_nxt = (total & low_mask) |
                 (OFFSET_BITS'(s4_side.pipe) << ib) |
                 (OFFSET_BITS'(s4_side.bank) << (ib + SH_BITS'(PIPE_BITS))) |
                 (high << (ib + SH_BITS'(PIPE_BITS + BANK_BITS)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte_offset = result_r;

endmodule

`default_nettype wire
